// ===== hw/rtl/masked_byte_pattern_search_macros.svh =====
// Assertion helpers for the masked byte pattern search block.
`ifndef MASKED_BYTE_PATTERN_SEARCH_MACROS_SVH
`define MASKED_BYTE_PATTERN_SEARCH_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MBPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define MBPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/mbps_pkg.sv =====
package mbps_pkg;

   localparam int ByteBits         = 8;
   localparam int CsrIndexBits     = 2;
   localparam int CsrDataBits      = 64;
   localparam int PatternPositions = 16;
   localparam int CareBits         = 16;
   localparam int LengthBits       = 5;

   // Configuration register indexes
   typedef enum logic [CsrIndexBits-1:0] {
      CSR_PATTERN_LOW    = 2'd0,
      CSR_PATTERN_HIGH   = 2'd1,
      CSR_CARE_MASK      = 2'd2,
      CSR_PATTERN_LENGTH = 2'd3
   } csr_index_type;

   // Control flags carried with each input beat
   typedef struct packed {
      logic first_of_region;
      logic new_search;
   } beat_flags_type;

   // Window status toward the top level
   typedef struct packed {
      logic hit;    // this beat produces a result
      logic found;  // a match was already reported in this search
   } window_status_type;

endpackage

// ===== hw/rtl/mbps_csr.sv =====
module mbps_csr #(
   parameter int MAX_PATTERN_BYTES = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        csr_valid,
   input  logic [mbps_pkg::CsrIndexBits-1:0]           csr_index,
   input  logic [mbps_pkg::CsrDataBits-1:0]            csr_data,
   output logic [MAX_PATTERN_BYTES-1:0][mbps_pkg::ByteBits-1:0] pat_aligned,
   output logic [MAX_PATTERN_BYTES-1:0]                care_aligned,
   output logic [$clog2(MAX_PATTERN_BYTES+1)-1:0]      len_eff
);

   localparam int LenBits = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int PosBits = $clog2(mbps_pkg::PatternPositions);

   logic [mbps_pkg::CsrDataBits-1:0] pattern_low_ff;
   logic [mbps_pkg::CsrDataBits-1:0] pattern_high_ff;
   logic [mbps_pkg::CareBits-1:0]    care_mask_ff;
   logic [mbps_pkg::LengthBits-1:0]  pattern_length_ff;
   logic [mbps_pkg::PatternPositions-1:0][mbps_pkg::ByteBits-1:0] pattern_all;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         care_mask_ff      <= '0;
         pattern_length_ff <= mbps_pkg::LengthBits'(1);
      end else if (csr_valid) begin
         unique case (mbps_pkg::csr_index_type'(csr_index))
            mbps_pkg::CSR_PATTERN_LOW:    pattern_low_ff  <= csr_data;
            mbps_pkg::CSR_PATTERN_HIGH:   pattern_high_ff <= csr_data;
            mbps_pkg::CSR_CARE_MASK:      care_mask_ff    <= csr_data[mbps_pkg::CareBits-1:0];
            mbps_pkg::CSR_PATTERN_LENGTH: begin
               pattern_length_ff <= csr_data[mbps_pkg::LengthBits-1:0];
            end
         endcase
      end
   end

   assign pattern_all = {pattern_high_ff, pattern_low_ff};

   // Clamp length: zero acts as one, oversize acts as the window depth
   always_comb begin
      if (pattern_length_ff == '0) begin
         len_eff = LenBits'(1);
      end else if (int'(pattern_length_ff) > MAX_PATTERN_BYTES) begin
         len_eff = LenBits'(MAX_PATTERN_BYTES);
      end else begin
         len_eff = LenBits'(pattern_length_ff);
      end
   end

   // Line the pattern up with the window: window slot j holds position len-1-j.
   // Slots past the pattern and positions from sixteen up are wildcards.
   always_comb begin
      int pos;
      pos = 0;
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
         pos             = int'(len_eff) - 1 - j;
         care_aligned[j] = 1'b0;
         pat_aligned[j]  = '0;
         if (pos >= 0 && pos < mbps_pkg::PatternPositions) begin
            care_aligned[j] = care_mask_ff[PosBits'(pos)];
            pat_aligned[j]  = pattern_all[PosBits'(pos)];
         end
      end
   end

endmodule

// ===== hw/rtl/mbps_window.sv =====
module mbps_window #(
   parameter int MAX_PATTERN_BYTES = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        fire,
   input  logic [mbps_pkg::ByteBits-1:0]               data_byte,
   input  mbps_pkg::beat_flags_type                    flags,
   input  logic [MAX_PATTERN_BYTES-1:0][mbps_pkg::ByteBits-1:0] pat_aligned,
   input  logic [MAX_PATTERN_BYTES-1:0]                care_aligned,
   input  logic [$clog2(MAX_PATTERN_BYTES+1)-1:0]      len_eff,
   output mbps_pkg::window_status_type                 status
);

   localparam int LenBits = $clog2(MAX_PATTERN_BYTES + 1);

   logic [MAX_PATTERN_BYTES-1:0][mbps_pkg::ByteBits-1:0] window_ff, window_in, window_base;
   logic [LenBits-1:0] fill_ff, fill_in, fill_base;
   logic               found_ff, found_in, found_base;
   logic               clear_win;
   logic               mismatch;

   assign clear_win  = flags.new_search | flags.first_of_region;
   assign found_base = found_ff & ~flags.new_search;

   // Emptied window for a region start or new search, then shift in the byte
   always_comb begin
      window_base = clear_win ? '0 : window_ff;
      fill_base   = clear_win ? '0 : fill_ff;
      window_in[0] = data_byte;
      for (int j = 1; j < MAX_PATTERN_BYTES; j++) begin
         window_in[j] = window_base[j-1];
      end
      fill_in = (fill_base < LenBits'(MAX_PATTERN_BYTES)) ? fill_base + LenBits'(1) : fill_base;
   end

   // Parallel masked compare over all slots
   always_comb begin
      mismatch = 1'b0;
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
         if (care_aligned[j] && (window_in[j] != pat_aligned[j])) begin
            mismatch = 1'b1;
         end
      end
   end

   assign status.hit   = fire & ~found_base & (fill_in >= len_eff) & ~mismatch;
   assign status.found = found_ff;
   assign found_in     = found_base | status.hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         fill_ff   <= '0;
         found_ff  <= 1'b0;
      end else if (fire) begin
         window_ff <= window_in;
         fill_ff   <= fill_in;
         found_ff  <= found_in;
      end
   end

endmodule

// ===== hw/rtl/masked_byte_pattern_search.sv =====
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_stall | data_byte, byte_address, first_of_region,
//         |           |                     | new_search
// rsp     | out       | rsp_valid/rsp_stall | match_address
// csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One beat per cycle is accepted while req_stall is low. Each accepted beat moves
// through the input register, then the window compare into the output register.
// The rate is set by the window shift and masked compare stage.
// Synchronous active-high reset empties the window and clears the found flag.
// A stalled result holds in the output register; the input stage keeps
// accepting until it holds a beat that cannot move on.
`include "masked_byte_pattern_search_macros.svh"

module masked_byte_pattern_search #(
   parameter int MAX_PATTERN_BYTES = 16,
   parameter int ADDRESS_BITS      = 48
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [mbps_pkg::ByteBits-1:0]     req_data_byte,
   input  logic [ADDRESS_BITS-1:0]           req_byte_address,
   input  logic                              req_first_of_region,
   input  logic                              req_new_search,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ADDRESS_BITS-1:0]           rsp_match_address,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mbps_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [mbps_pkg::CsrDataBits-1:0]  csr_data
);

   localparam int LenBits = $clog2(MAX_PATTERN_BYTES + 1);

   logic [MAX_PATTERN_BYTES-1:0][mbps_pkg::ByteBits-1:0] pat_aligned;
   logic [MAX_PATTERN_BYTES-1:0] care_aligned;
   logic [LenBits-1:0]           len_eff;

   logic                           s1_valid_ff, s1_valid_in;
   logic [mbps_pkg::ByteBits-1:0]  s1_byte_ff;
   logic [ADDRESS_BITS-1:0]        s1_addr_ff;
   mbps_pkg::beat_flags_type       s1_flags_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [ADDRESS_BITS-1:0]        rsp_addr_ff;
   logic                           out_ready;
   logic                           req_accept;
   logic                           s1_fire;
   mbps_pkg::window_status_type    status;

   assign csr_ready = 1'b1;

   mbps_csr #(
      .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .pat_aligned  (pat_aligned),
      .care_aligned (care_aligned),
      .len_eff      (len_eff)
   );

   // Handshake: input stage moves on when the output register has room
   assign out_ready   = ~rsp_valid_ff | ~rsp_stall;
   assign s1_fire     = s1_valid_ff & out_ready;
   assign req_stall   = s1_valid_ff & ~out_ready;
   assign req_accept  = req_valid & ~req_stall;
   assign s1_valid_in = req_accept | (s1_valid_ff & ~s1_fire);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff                  <= req_data_byte;
         s1_addr_ff                  <= req_byte_address;
         s1_flags_ff.first_of_region <= req_first_of_region;
         s1_flags_ff.new_search      <= req_new_search;
      end
   end

   mbps_window #(
      .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
   ) u_window (
      .clock        (clock),
      .reset        (reset),
      .fire         (s1_fire),
      .data_byte    (s1_byte_ff),
      .flags        (s1_flags_ff),
      .pat_aligned  (pat_aligned),
      .care_aligned (care_aligned),
      .len_eff      (len_eff),
      .status       (status)
   );

   // Output register
   assign rsp_valid_in = status.hit | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Match start: address of the newest byte minus (length - 1), wrapped
   always_ff @(posedge clock) begin
      if (status.hit) begin
         rsp_addr_ff <= s1_addr_ff - ADDRESS_BITS'(len_eff - LenBits'(1));
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_match_address = rsp_addr_ff;

   // Checks
   `MBPS_ASSERT_NOW(a_stall_needs_beat, clock, reset,
      req_stall, s1_valid_ff, "stall with empty input stage")
   `MBPS_ASSERT_NEXT(a_hit_sets_found, clock, reset,
      status.hit, status.found, "found flag not set after a match")
   `MBPS_ASSERT_NOW(a_one_result_per_search, clock, reset,
      status.found && !s1_flags_ff.new_search, !status.hit, "second result in one search")
   `MBPS_ASSERT_NOW(a_result_from_hit, clock, reset,
      $rose(rsp_valid_ff), $past(status.hit), "result without a match")

endmodule
